// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned TagW   = 16;
  localparam int unsigned FieldW = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic {
    SPQ_PUSH = 1'b0,
    SPQ_POP  = 1'b1
  } spq_kind_e;

  typedef enum logic [1:0] {
    SPQ_OK         = 2'd0,
    SPQ_POP_EMPTY  = 2'd1,
    SPQ_PUSH_FULL  = 2'd2
  } spq_status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

// ===== rtl/core/spq_req_if.sv =====
// Request channel: push or pop word with valid/ready handshake.
interface spq_req_if;
  logic                               valid;
  logic                               ready;
  spq_pkg::spq_kind_e                 kind;
  logic [spq_pkg::FieldW-1:0]         priority_req;
  logic [spq_pkg::TagW-1:0]           tag;

  modport source (output valid, output kind, output priority_req, output tag, input ready);
  modport sink   (input valid, input kind, input priority_req, input tag, output ready);
endinterface

// ===== rtl/core/spq_rsp_if.sv =====
// Response channel: status, popped entry and count with valid/ready handshake.
interface spq_rsp_if;
  logic                               valid;
  logic                               ready;
  spq_pkg::spq_status_e               status;
  logic [spq_pkg::FieldW-1:0]         popped_priority;
  logic [spq_pkg::TagW-1:0]           popped_tag;
  logic                               popped_valid;
  logic [spq_pkg::CountW-1:0]         entry_count;

  modport source (output valid, output status, output popped_priority, output popped_tag,
                  output popped_valid, output entry_count, input ready);
  modport sink   (input valid, input status, input popped_priority, input popped_tag,
                  input popped_valid, input entry_count, output ready);
endinterface

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell #(
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic                      clk_i,
  input  spq_pkg::spq_cmd_t         cmd_i,
  input  logic                      occupied_i,
  input  logic [PRIORITY_WIDTH-1:0] new_prio_i,
  input  logic [spq_pkg::TagW-1:0]  new_tag_i,
  input  logic                      left_keep_i,
  input  logic [PRIORITY_WIDTH-1:0] left_prio_i,
  input  logic [spq_pkg::TagW-1:0]  left_tag_i,
  input  logic [PRIORITY_WIDTH-1:0] right_prio_i,
  input  logic [spq_pkg::TagW-1:0]  right_tag_i,
  output logic                      keep_o,
  output logic [PRIORITY_WIDTH-1:0] prio_o,
  output logic [spq_pkg::TagW-1:0]  tag_o
);

  logic [PRIORITY_WIDTH-1:0] prio_q, prio_d;
  logic [spq_pkg::TagW-1:0]  tag_q, tag_d;

  // Stay in place when held entry ranks at or above the newcomer.
  assign keep_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    if (cmd_i.push) begin
      if (keep_o) begin
        prio_d = prio_q;
        tag_d  = tag_q;
      end else if (left_keep_i) begin
        prio_d = new_prio_i;
        tag_d  = new_tag_i;
      end else begin
        prio_d = left_prio_i;
        tag_d  = left_tag_i;
      end
    end else if (cmd_i.pop) begin
      prio_d = right_prio_i;
      tag_d  = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Results are registered: each appears in the cycle after its request is accepted.
// Throughput: one request word per cycle while the result side keeps taking words;
//   every cell compares and shifts in the same cycle, so no operation iterates.
// Reset: clears the entry count and the result valid flag; slot contents stay
//   undefined until written and are never read before that.
module sorted_priority_queue #(
  parameter int unsigned DEPTH          = 16,
  parameter int unsigned PRIORITY_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spq_req_if.sink      req_i,
  spq_rsp_if.source    rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned PW   = PRIORITY_WIDTH;
  localparam int unsigned FW   = spq_pkg::FieldW;
  localparam int unsigned TW   = spq_pkg::TagW;

  // ---------------------------------------------------------------------------
  // Handshake: the result register frees up when its word is taken, so a new
  // request is taken in the same cycle the old result leaves.
  // ---------------------------------------------------------------------------
  logic req_acc;
  logic rsp_vld_q;

  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Occupancy and command decode
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  logic            is_push, is_pop;
  spq_pkg::spq_cmd_t cmd;

  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);
  assign is_push = (req_i.kind == spq_pkg::SPQ_PUSH);
  assign is_pop  = (req_i.kind == spq_pkg::SPQ_POP);

  // Drop a push to a full queue and a pop from an empty one: chain holds.
  assign cmd.push = req_acc && is_push && !full;
  assign cmd.pop  = req_acc && is_pop && !empty;

  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Keep only the low PRIORITY_WIDTH bits of the requested priority.
  logic [PW+FW-1:0] prio_in_ext;
  logic [PW-1:0]    new_prio;

  assign prio_in_ext = {{PW{1'b0}}, req_i.priority_req};
  assign new_prio    = prio_in_ext[PW-1:0];

  // ---------------------------------------------------------------------------
  // Chain of cells, head at slot 0. On push each cell either keeps its entry,
  // takes the new one (first cell that yields) or takes its left neighbor's;
  // on pop every cell takes its right neighbor's entry, the tail its own.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] cell_prio [DEPTH];
  logic [TW-1:0] cell_tag  [DEPTH];
  logic          cell_keep [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          occupied;
    logic          left_keep;
    logic [PW-1:0] left_prio, right_prio;
    logic [TW-1:0] left_tag, right_tag;

    assign occupied = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_prio = new_prio;
      assign left_tag  = req_i.tag;
    end else begin : g_body
      assign left_keep = cell_keep[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_tag  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = cell_prio[i];
      assign right_tag  = cell_tag[i];
    end else begin : g_inner
      assign right_prio = cell_prio[i+1];
      assign right_tag  = cell_tag[i+1];
    end

    spq_cell #(
      .PRIORITY_WIDTH (PW)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (occupied),
      .new_prio_i   (new_prio),
      .new_tag_i    (req_i.tag),
      .left_keep_i  (left_keep),
      .left_prio_i  (left_prio),
      .left_tag_i   (left_tag),
      .right_prio_i (right_prio),
      .right_tag_i  (right_tag),
      .keep_o       (cell_keep[i]),
      .prio_o       (cell_prio[i]),
      .tag_o        (cell_tag[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register: capture status, head entry and the updated count.
  // ---------------------------------------------------------------------------
  logic [PW+FW-1:0]        head_ext;
  logic [CntW+4:0]         count_ext;
  spq_pkg::spq_status_e    status_d, status_q;
  logic [FW-1:0]           pop_prio_d, pop_prio_q;
  logic [TW-1:0]           pop_tag_d, pop_tag_q;
  logic                    pop_vld_d, pop_vld_q;
  logic [spq_pkg::CountW-1:0] cnt_out_q;

  assign head_ext  = {{FW{1'b0}}, cell_prio[0]};
  assign count_ext = {5'd0, count_d};

  always_comb begin
    status_d   = spq_pkg::SPQ_OK;
    pop_prio_d = '0;
    pop_tag_d  = '0;
    pop_vld_d  = 1'b0;
    if (is_push && full) begin
      status_d = spq_pkg::SPQ_PUSH_FULL;
    end else if (is_pop && empty) begin
      status_d = spq_pkg::SPQ_POP_EMPTY;
    end else if (is_pop) begin
      pop_prio_d = head_ext[FW-1:0];
      pop_tag_d  = cell_tag[0];
      pop_vld_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_vld_q <= req_i.valid;
    end
  end

  // Hold payload while the result waits; load it on each accepted request.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      status_q   <= status_d;
      pop_prio_q <= pop_prio_d;
      pop_tag_q  <= pop_tag_d;
      pop_vld_q  <= pop_vld_d;
      cnt_out_q  <= count_ext[spq_pkg::CountW-1:0];
    end
  end

  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.popped_priority = pop_prio_q;
  assign rsp_o.popped_tag      = pop_tag_q;
  assign rsp_o.popped_valid    = pop_vld_q;
  assign rsp_o.entry_count     = cnt_out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && is_push && !full) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("accepted push did not add an entry");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && is_pop && empty) |=>
      (rsp_o.valid && rsp_o.status == spq_pkg::SPQ_POP_EMPTY && !rsp_o.popped_valid))
    else $error("pop on empty queue not flagged");

  a_popped_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.popped_valid) |-> (rsp_o.status == spq_pkg::SPQ_OK))
    else $error("popped entry with error status");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_prio[0] >= cell_prio[1]))
    else $error("head slot out of order");
`endif

endmodule

// ===== tb/sorted_priority_queue_test.sv =====
// Self-checking testbench for the sorted priority queue: directed and random push/pop words.
`timescale 1ns / 100ps

module sorted_priority_queue_test;

  localparam int unsigned QDepth     = 16;
  localparam int unsigned PrioW      = 16;
  localparam int unsigned RandWords  = 1750;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [spq_pkg::FieldW-1:0] PrioMask =
    spq_pkg::FieldW'((64'd1 << PrioW) - 64'd1);

  // How the priorities of a run of pushes are spread.
  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_FEW,
    SPREAD_EXTREME,
    SPREAD_TOP
  } prio_spread_e;

  // Shape of one random phase.
  typedef enum int unsigned {
    SHAPE_FILL_DRAIN,
    SHAPE_MIX,
    SHAPE_OVERFLOW
  } phase_shape_e;

  typedef struct {
    spq_pkg::spq_status_e       status;
    logic [spq_pkg::FieldW-1:0] prio;
    logic [spq_pkg::TagW-1:0]   tag;
    logic                       popped;
    logic [spq_pkg::CountW-1:0] count;
  } result_word_t;

  // Shadow copy of the queue contents plus the result words still owed by the block.
  class queue_mirror;
    logic [spq_pkg::FieldW-1:0] slot_prio [QDepth];
    logic [spq_pkg::TagW-1:0]   slot_tag  [QDepth];
    int unsigned                held;
    result_word_t               owed_results [$];
    int unsigned                mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Apply one accepted request word and queue the result it must produce.
    function void note_request(spq_pkg::spq_kind_e kind, logic [spq_pkg::FieldW-1:0] prio,
                               logic [spq_pkg::TagW-1:0] tag);
      result_word_t w;
      logic [spq_pkg::FieldW-1:0] p;
      int unsigned pos;
      int unsigned i;
      w.status = spq_pkg::SPQ_OK;
      w.prio   = '0;
      w.tag    = '0;
      w.popped = 1'b0;
      p        = prio & PrioMask;
      if (kind == spq_pkg::SPQ_PUSH) begin
        if (held >= QDepth) begin
          w.status = spq_pkg::SPQ_PUSH_FULL;
        end else begin
          // Land behind every entry of greater or equal priority.
          pos = 0;
          while (pos < held && slot_prio[pos] >= p) pos++;
          for (i = held; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_prio[pos] = p;
          slot_tag[pos]  = tag;
          held++;
        end
      end else begin
        if (held == 0) begin
          w.status = spq_pkg::SPQ_POP_EMPTY;
        end else begin
          w.prio   = slot_prio[0];
          w.tag    = slot_tag[0];
          w.popped = 1'b1;
          for (i = 1; i < held; i++) begin
            slot_prio[i-1] = slot_prio[i];
            slot_tag[i-1]  = slot_tag[i];
          end
          held--;
        end
      end
      w.count = spq_pkg::CountW'(held);
      owed_results.push_back(w);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        mismatches++;
      end
    endfunction

    // Match one accepted result word against the oldest owed one.
    function void check_result(result_word_t got);
      result_word_t want;
      if (owed_results.size() == 0) begin
        $error("result word with no request outstanding: status 0x%0h count %0d",
               got.status, got.count);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("popped_priority", want.prio, got.prio);
      compare_field("popped_tag", want.tag, got.tag);
      compare_field("popped_valid", want.popped, got.popped);
      compare_field("entry_count", want.count, got.count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue #(
    .DEPTH          (QDepth),
    .PRIORITY_WIDTH (PrioW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  queue_mirror mirror;

  bit          send_eager;      // sender skips its idle gaps while set
  int unsigned random_sent;     // random request words accepted so far
  int unsigned hold_requests;   // long result-side hold-offs asked by the sender
  int unsigned holds_done;      // long hold-offs carried out by the receiver
  int unsigned results_seen;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [spq_pkg::FieldW-1:0] pick_priority(prio_spread_e spread);
    case (spread)
      SPREAD_FEW:     return spq_pkg::FieldW'($urandom_range(3));
      SPREAD_EXTREME: return ($urandom_range(1) == 0) ? '0 : '1;
      SPREAD_TOP:     return spq_pkg::FieldW'(16'hFFFF - $urandom_range(3));
      default:        return spq_pkg::FieldW'($urandom);
    endcase
  endfunction

  // Offer one request word after a random idle gap; hold it until the block takes it.
  task automatic send_word(spq_pkg::spq_kind_e kind, logic [spq_pkg::FieldW-1:0] prio,
                           logic [spq_pkg::TagW-1:0] tag);
    int unsigned gap;
    gap = send_eager ? 0 : $urandom_range(6);
    repeat (gap) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_bus.valid        <= 1'b1;
    req_bus.kind         <= kind;
    req_bus.priority_req <= prio;
    req_bus.tag          <= tag;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    mirror.note_request(kind, prio, tag);
  endtask

  task automatic push_some(int unsigned n, prio_spread_e spread);
    repeat (n) send_word(spq_pkg::SPQ_PUSH, pick_priority(spread),
                         spq_pkg::TagW'($urandom));
  endtask

  // Pops carry random noise in the ignored priority and tag fields.
  task automatic pop_some(int unsigned n);
    repeat (n) send_word(spq_pkg::SPQ_POP, spq_pkg::FieldW'($urandom),
                         spq_pkg::TagW'($urandom));
  endtask

  // Drop valid and stall until every owed result word has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, fast stretches, and long hold-offs on request.
  initial begin
    result_word_t got;
    int unsigned  stall;
    bit           rsp_eager;
    rsp_bus.ready = 1'b0;
    results_seen  = 0;
    holds_done    = 0;
    rsp_eager     = 1'b0;
    forever begin
      if (holds_done < hold_requests) begin
        // Block the result side long enough for the queue to back up into the input.
        holds_done++;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          rsp_bus.ready <= 1'b0;
        end
      end
      if (results_seen % 64 == 0) rsp_eager = ($urandom_range(2) == 0);
      stall = rsp_eager ? 0 : $urandom_range(6);
      repeat (stall) begin
        @(negedge clk_i);
        rsp_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_bus.valid) @(posedge clk_i);
      got.status = rsp_bus.status;
      got.prio   = rsp_bus.popped_priority;
      got.tag    = rsp_bus.popped_tag;
      got.popped = rsp_bus.popped_valid;
      got.count  = rsp_bus.entry_count;
      mirror.check_result(got);
      results_seen++;
    end
  end

  // Request side: reset, directed words, then random phases.
  initial begin
    phase_shape_e shape;
    prio_spread_e spread;
    int unsigned  phase;
    int unsigned  len;
    int unsigned  bias;
    mirror               = new();
    send_eager           = 1'b0;
    hold_requests        = 0;
    random_sent          = 0;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.kind         = spq_pkg::SPQ_PUSH;
    req_bus.priority_req = '0;
    req_bus.tag          = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pop from the empty queue first.
    pop_some(1);
    // Extremes of priority and tag, plus ties at the top that must leave in arrival order.
    send_word(spq_pkg::SPQ_PUSH, 16'h0000, 16'hFFFF);
    send_word(spq_pkg::SPQ_PUSH, 16'hFFFF, 16'h0001);
    send_word(spq_pkg::SPQ_PUSH, 16'h8000, 16'hAAAA);
    send_word(spq_pkg::SPQ_PUSH, 16'hFFFF, 16'h0002);
    send_word(spq_pkg::SPQ_PUSH, 16'h0001, 16'h5555);
    send_word(spq_pkg::SPQ_PUSH, 16'hFFFF, 16'h0003);
    send_word(spq_pkg::SPQ_PUSH, 16'h8000, 16'h0000);
    push_some(9, SPREAD_FULL);
    // Queue is full: a top-priority push must be dropped.
    send_word(spq_pkg::SPQ_PUSH, 16'hFFFF, 16'hBEEF);
    pop_some(6);
    wait_drained();

    phase = 0;
    while (random_sent < RandWords) begin
      shape      = phase_shape_e'($urandom_range(2));
      spread     = prio_spread_e'($urandom_range(3));
      send_eager = ($urandom_range(3) == 0);
      if (phase == 2 || phase == 17) hold_requests++;
      len = 0;
      case (shape)
        SHAPE_FILL_DRAIN: begin
          len = $urandom_range(1, QDepth);
          push_some(len, spread);
          pop_some($urandom_range(len, len + 2));
          len = 2 * len + 1;
        end
        SHAPE_OVERFLOW: begin
          // Run past full and past empty.
          push_some(QDepth + $urandom_range(1, 4), spread);
          pop_some(QDepth + $urandom_range(1, 4));
          len = 2 * QDepth + 4;
        end
        default: begin
          len  = $urandom_range(10, 60);
          bias = $urandom_range(30, 70);
          repeat (len) begin
            if ($urandom_range(99) < bias) push_some(1, spread);
            else pop_some(1);
          end
        end
      endcase
      random_sent += len;
      if (phase % 4 == 3) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
